// ----- sv/lphm_pkg.sv -----
`default_nettype none

package lphm_pkg;

    localparam int unsigned CAPACITY_DEF = 1024;

    localparam int unsigned OP_W  = 2;
    localparam int unsigned KEY_W = 31;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned CNT_W = 11;
    localparam int unsigned RS_W  = 2;

    // home-slot remainder: key padded to 32 bits, 4 bits folded in per cycle
    localparam int unsigned DIV_BITS  = 4;
    localparam int unsigned DIV_W     = 32;
    localparam int unsigned DIV_STEPS = DIV_W / DIV_BITS;

    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned M_TDATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2
    } opcode_t;

    typedef enum logic [RS_W-1:0] {
        RS_OK        = 2'd0,
        RS_NOT_FOUND = 2'd1,
        RS_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_USED  = 2'd1,
        SLOT_GONE  = 2'd2
    } slot_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- sv/linear_probe_hash_map.sv -----
`default_nettype none

// Key/value table with open addressing and linear probing over CAPACITY slots.
// s_tuser carries the opcode (insert, delete, lookup); one result beat per
// request. After reset the block sweeps every entry of the slot-status memory
// (s_tready low) before taking the first request. Each probed slot takes a
// registered memory read, then a compare/update; a request probes 1 to
// CAPACITY slots, the unused opcode none. When CAPACITY is not a power of two
// the home slot comes from a 4-bit-per-cycle remainder unit, run before the
// first probe of every request that probes. A full table on insert returns
// status 2; a miss returns status 1 with value 0. entry_count wraps modulo 2048.
module linear_probe_hash_map #(
    parameter int unsigned CAPACITY = lphm_pkg::CAPACITY_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [30:0] req_key, [62:31] req_value, [63] zero
    input  wire logic [lphm_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] opcode
    input  wire logic [lphm_pkg::OP_W-1:0]      s_tuser,

    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [31:0] result_value, [42:32] entry_count, [47:43] zero
    output logic [lphm_pkg::M_TDATA_W-1:0]      m_tdata,
    // [1:0] status
    output logic [lphm_pkg::RS_W-1:0]           m_tuser
);

    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam bit IS_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
    localparam logic [IDX_W:0]   CAP_W    = (IDX_W+1)'(CAPACITY);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
    localparam int unsigned KEY_W = lphm_pkg::KEY_W;
    localparam int unsigned VAL_W = lphm_pkg::VAL_W;
    localparam int unsigned CNT_W = lphm_pkg::CNT_W;
    localparam int unsigned DIV_BITS = lphm_pkg::DIV_BITS;
    localparam int unsigned DIV_W = lphm_pkg::DIV_W;
    localparam int unsigned DCNT_W = $clog2(lphm_pkg::DIV_STEPS);
    localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(lphm_pkg::DIV_STEPS - 1);

    // restoring remainder, DIV_BITS key bits per call, MSB first
    function automatic logic [IDX_W-1:0] rem_step(input logic [IDX_W-1:0] r_in,
                                                  input logic [DIV_BITS-1:0] bits);
        logic [IDX_W-1:0] r;
        logic [IDX_W:0]   t;
        r = r_in;
        for (int i = DIV_BITS - 1; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= CAP_W) begin
                t = t - CAP_W;
            end
            r = t[IDX_W-1:0];
        end
        return r;
    endfunction

    // slot memories
    logic [KEY_W-1:0] slot_key_mem   [CAPACITY];
    logic [VAL_W-1:0] slot_value_mem [CAPACITY];
    logic [1:0]       slot_stat_mem  [CAPACITY];

    lphm_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  probe_cnt_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [DIV_W-1:0]  div_sh_reg;
    logic [1:0]        op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [CNT_W-1:0]  count_reg;

    logic [KEY_W-1:0]  key_rd_reg;
    logic [VAL_W-1:0]  val_rd_reg;
    logic [1:0]        stat_rd_reg;

    logic [1:0]        res_status_reg;
    logic [VAL_W-1:0]  res_value_reg;

    logic              m_tvalid_reg;
    logic [1:0]        m_status_reg;
    logic [VAL_W-1:0]  m_value_reg;
    logic [CNT_W-1:0]  m_count_reg;

    logic              in_beat;
    logic              out_load;
    logic              stat_we;
    logic [1:0]        stat_wdata;
    logic              kv_we;
    logic              clear_last;
    logic              div_last;
    logic [IDX_W-1:0]  rem_new;
    logic [IDX_W-1:0]  idx_inc;
    logic [1:0]        in_op;

    logic              ev_finish;
    logic [1:0]        ev_status;
    logic [VAL_W-1:0]  ev_result;
    logic              ev_write_used;
    logic              ev_write_gone;
    logic              ev_inc;
    logic              ev_dec;
    logic              ev_hit;
    logic              ev_last;

    assign in_op      = s_tuser;
    assign in_beat    = s_tvalid && s_tready;
    assign clear_last = (idx_reg == IDX_LAST);
    assign div_last   = (div_cnt_reg == DCNT_LAST);
    assign rem_new    = rem_step(idx_reg, div_sh_reg[DIV_W-1 -: DIV_BITS]);
    assign idx_inc    = (idx_reg == IDX_LAST) ? '0 : idx_reg + IDX_W'(1);

    // probe decision on the slot just read
    always_comb begin
        ev_hit        = (key_rd_reg == key_reg);
        ev_last       = (probe_cnt_reg == IDX_LAST);
        ev_finish     = 1'b0;
        ev_status     = lphm_pkg::RS_OK;
        ev_result     = '0;
        ev_write_used = 1'b0;
        ev_write_gone = 1'b0;
        ev_inc        = 1'b0;
        ev_dec        = 1'b0;
        if (op_reg == lphm_pkg::OP_INSERT) begin
            if (stat_rd_reg != lphm_pkg::SLOT_USED || ev_hit) begin
                ev_finish     = 1'b1;
                ev_write_used = 1'b1;
                ev_inc        = (stat_rd_reg != lphm_pkg::SLOT_USED);
            end else if (ev_last) begin
                ev_finish = 1'b1;
                ev_status = lphm_pkg::RS_FULL;
            end
        end else begin
            if (stat_rd_reg == lphm_pkg::SLOT_EMPTY) begin
                ev_finish = 1'b1;
                ev_status = lphm_pkg::RS_NOT_FOUND;
            end else if (stat_rd_reg == lphm_pkg::SLOT_USED && ev_hit) begin
                ev_finish = 1'b1;
                ev_result = val_rd_reg;
                if (op_reg == lphm_pkg::OP_DELETE) begin
                    ev_write_gone = 1'b1;
                    ev_dec        = 1'b1;
                end
            end else if (ev_last) begin
                ev_finish = 1'b1;
                ev_status = lphm_pkg::RS_NOT_FOUND;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lphm_pkg::ST_CLEAR: begin
                if (clear_last) begin
                    state_next = lphm_pkg::ST_IDLE;
                end
            end
            lphm_pkg::ST_IDLE: begin
                if (in_beat) begin
                    if (in_op != lphm_pkg::OP_INSERT && in_op != lphm_pkg::OP_DELETE &&
                        in_op != lphm_pkg::OP_LOOKUP) begin
                        state_next = lphm_pkg::ST_DONE;
                    end else if (IS_POW2) begin
                        state_next = lphm_pkg::ST_READ;
                    end else begin
                        state_next = lphm_pkg::ST_DIV;
                    end
                end
            end
            lphm_pkg::ST_DIV: begin
                if (div_last) begin
                    state_next = lphm_pkg::ST_READ;
                end
            end
            lphm_pkg::ST_READ: begin
                state_next = lphm_pkg::ST_EVAL;
            end
            lphm_pkg::ST_EVAL: begin
                state_next = ev_finish ? lphm_pkg::ST_DONE : lphm_pkg::ST_READ;
            end
            lphm_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = lphm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lphm_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_tready   = 1'b0;
        stat_we    = 1'b0;
        stat_wdata = lphm_pkg::SLOT_EMPTY;
        kv_we      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            lphm_pkg::ST_CLEAR: begin
                stat_we = 1'b1;
            end
            lphm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            lphm_pkg::ST_EVAL: begin
                stat_we    = ev_write_used || ev_write_gone;
                stat_wdata = ev_write_used ? lphm_pkg::SLOT_USED : lphm_pkg::SLOT_GONE;
                kv_we      = ev_write_used;
            end
            lphm_pkg::ST_DONE: begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lphm_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // sequencer datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            probe_cnt_reg <= '0;
            div_cnt_reg   <= '0;
            count_reg     <= '0;
        end else begin
            case (state_reg)
                lphm_pkg::ST_CLEAR: begin
                    idx_reg <= idx_inc;
                end
                lphm_pkg::ST_IDLE: begin
                    if (in_beat) begin
                        idx_reg       <= IS_POW2 ? s_tdata[IDX_W-1:0] : '0;
                        probe_cnt_reg <= '0;
                        div_cnt_reg   <= '0;
                    end
                end
                lphm_pkg::ST_DIV: begin
                    idx_reg     <= rem_new;
                    div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
                end
                lphm_pkg::ST_EVAL: begin
                    if (!ev_finish) begin
                        idx_reg       <= idx_inc;
                        probe_cnt_reg <= probe_cnt_reg + IDX_W'(1);
                    end
                    if (ev_inc) begin
                        count_reg <= count_reg + CNT_W'(1);
                    end else if (ev_dec) begin
                        count_reg <= count_reg - CNT_W'(1);
                    end
                end
                default: begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    // request capture and result hold
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            op_reg        <= in_op;
            key_reg       <= s_tdata[KEY_W-1:0];
            val_reg       <= s_tdata[KEY_W +: VAL_W];
            div_sh_reg    <= {{(DIV_W-KEY_W){1'b0}}, s_tdata[KEY_W-1:0]};
            res_status_reg <= lphm_pkg::RS_OK;
            res_value_reg  <= '0;
        end else if (state_reg == lphm_pkg::ST_DIV) begin
            div_sh_reg <= div_sh_reg << DIV_BITS;
        end else if (state_reg == lphm_pkg::ST_EVAL && ev_finish) begin
            res_status_reg <= ev_status;
            res_value_reg  <= ev_result;
        end
    end

    // memories: single address, registered read
    always_ff @(posedge aclk) begin
        if (stat_we) begin
            slot_stat_mem[idx_reg] <= stat_wdata;
        end
        stat_rd_reg <= slot_stat_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (kv_we) begin
            slot_key_mem[idx_reg]   <= key_reg;
            slot_value_mem[idx_reg] <= val_reg;
        end
        key_rd_reg <= slot_key_mem[idx_reg];
        val_rd_reg <= slot_value_mem[idx_reg];
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_value_reg  <= res_value_reg;
            m_count_reg  <= count_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(lphm_pkg::M_TDATA_W - VAL_W - CNT_W){1'b0}}, m_count_reg, m_value_reg};

    // occupancy never exceeds the table size (when the count does not wrap)
    assert property (@(posedge aclk) disable iff (!aresetn)
        (CAPACITY > 2047) || (32'(count_reg) <= 32'(CAPACITY)))
        else $error("entry count above capacity");

    // one request at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> !s_tready)
        else $error("request taken while busy");

    // table-full is only reported for an insert
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && res_status_reg == lphm_pkg::RS_FULL) |-> (op_reg == lphm_pkg::OP_INSERT))
        else $error("full status on a non-insert");

    // the count moves only on a probe decision
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != lphm_pkg::ST_EVAL) |=> $stable(count_reg))
        else $error("entry count changed outside probe");

    // a slot's key and value are written only on a finishing insert probe
    assert property (@(posedge aclk) disable iff (!aresetn)
        kv_we |-> (ev_finish && op_reg == lphm_pkg::OP_INSERT))
        else $error("slot written without a placed insert");

endmodule

`default_nettype wire

// ----- dv/linear_probe_hash_map_tb.sv -----
`timescale 1ns / 1ps

module linear_probe_hash_map_tb;

    localparam int unsigned OP_W      = lphm_pkg::OP_W;
    localparam int unsigned KEY_W     = lphm_pkg::KEY_W;
    localparam int unsigned VAL_W     = lphm_pkg::VAL_W;
    localparam int unsigned CNT_W     = lphm_pkg::CNT_W;
    localparam int unsigned RS_W      = lphm_pkg::RS_W;
    localparam int unsigned S_TDATA_W = lphm_pkg::S_TDATA_W;
    localparam int unsigned M_TDATA_W = lphm_pkg::M_TDATA_W;

    localparam int unsigned SLOTS        = lphm_pkg::CAPACITY_DEF;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
    localparam int unsigned STALL_LIMIT  = 8000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned RANDOM_REQS  = 600;

    // keys that home on the last slot or on slot 0
    localparam logic [KEY_W-1:0] LAST_HOME  = KEY_W'(SLOTS - 1);
    localparam logic [KEY_W-1:0] LAST_TWIN  = KEY_W'(2 * SLOTS - 1);
    localparam logic [KEY_W-1:0] ZERO_TWIN  = KEY_W'(SLOTS);

    typedef struct packed {
        lphm_pkg::status_t status;
        logic [VAL_W-1:0]  value;
        logic [CNT_W-1:0]  count;
    } reply_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]      s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [RS_W-1:0]      m_tuser;

    linear_probe_hash_map #(
        .CAPACITY(SLOTS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // shadow of the slot table
    logic [KEY_W-1:0] tbl_key   [SLOTS];
    logic [VAL_W-1:0] tbl_value [SLOTS];
    lphm_pkg::slot_t  tbl_state [SLOTS];
    logic [CNT_W-1:0] tbl_count;

    reply_t      pending_replies[$];
    int unsigned fail_count      = 0;
    int unsigned reqs_sent       = 0;
    int unsigned replies_checked = 0;
    int unsigned misses_seen     = 0;
    int unsigned full_seen       = 0;
    int unsigned quiet_cycles    = 0;
    bit          no_idle         = 1'b0;

    function automatic int unsigned draw_wait();
        draw_wait = no_idle ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic bit probe_for_key(input logic [KEY_W-1:0] key,
                                         output int unsigned where);
        int unsigned idx;
        bit          hit;
        bit          stop;
        idx   = key % SLOTS;
        hit   = 1'b0;
        stop  = 1'b0;
        where = 0;
        for (int unsigned n = 0; n < SLOTS && !stop; n++) begin
            if (tbl_state[idx] == lphm_pkg::SLOT_EMPTY) begin
                stop = 1'b1;
            end else if (tbl_state[idx] == lphm_pkg::SLOT_USED && tbl_key[idx] == key) begin
                hit   = 1'b1;
                stop  = 1'b1;
                where = idx;
            end else begin
                idx = (idx + 1) % SLOTS;
            end
        end
        return hit;
    endfunction

    function automatic reply_t apply_request(input logic [OP_W-1:0]  op,
                                             input logic [KEY_W-1:0] key,
                                             input logic [VAL_W-1:0] value);
        reply_t      r;
        int unsigned idx;
        bit          placed;
        r.status = lphm_pkg::RS_OK;
        r.value  = '0;
        placed   = 1'b0;
        case (op)
            lphm_pkg::OP_INSERT: begin
                idx = key % SLOTS;
                // first free or tombstoned slot, or the key itself, wins
                for (int unsigned n = 0; n < SLOTS && !placed; n++) begin
                    if (tbl_state[idx] != lphm_pkg::SLOT_USED || tbl_key[idx] == key) begin
                        if (tbl_state[idx] != lphm_pkg::SLOT_USED)
                            tbl_count++;
                        tbl_state[idx] = lphm_pkg::SLOT_USED;
                        tbl_key[idx]   = key;
                        tbl_value[idx] = value;
                        placed         = 1'b1;
                    end else begin
                        idx = (idx + 1) % SLOTS;
                    end
                end
                if (!placed)
                    r.status = lphm_pkg::RS_FULL;
            end
            lphm_pkg::OP_DELETE: begin
                if (probe_for_key(key, idx)) begin
                    r.value        = tbl_value[idx];
                    tbl_state[idx] = lphm_pkg::SLOT_GONE;
                    tbl_count--;
                end else begin
                    r.status = lphm_pkg::RS_NOT_FOUND;
                end
            end
            lphm_pkg::OP_LOOKUP: begin
                if (probe_for_key(key, idx))
                    r.value = tbl_value[idx];
                else
                    r.status = lphm_pkg::RS_NOT_FOUND;
            end
            default: ;
        endcase
        r.count = tbl_count;
        return r;
    endfunction

    task automatic send_request(input logic [OP_W-1:0]  op,
                                input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value);
        int unsigned gap;
        reply_t      r;
        gap = draw_wait();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, value, key};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        r = apply_request(op, key, value);
        pending_replies.push_back(r);
        reqs_sent++;
        if (reqs_sent % 40 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
    endtask

    task automatic test_directed_corners();
        logic [31:0] raw;
        send_request(lphm_pkg::OP_LOOKUP, '0, '0);             // empty table miss
        send_request(lphm_pkg::OP_DELETE, '0, '0);
        send_request(lphm_pkg::OP_INSERT, '0, 32'h7FFF_FFFF);
        // max key, last slot
        send_request(lphm_pkg::OP_INSERT, 31'h7FFF_FFFF, 32'h8000_0000);
        send_request(lphm_pkg::OP_INSERT, LAST_HOME, 32'h1234_5678); // wraps past slot 0
        send_request(lphm_pkg::OP_LOOKUP, LAST_HOME, '0);
        send_request(lphm_pkg::OP_INSERT, '0, 32'hFFFF_FFFF);  // overwrite in place
        send_request(lphm_pkg::OP_LOOKUP, '0, '0);
        send_request(lphm_pkg::OP_DELETE, 31'h7FFF_FFFF, '0);  // leaves a tombstone
        send_request(lphm_pkg::OP_LOOKUP, 31'h7FFF_FFFF, '0);
        // tombstone ahead of the live copy: insert lands there, key now twice
        send_request(lphm_pkg::OP_INSERT, LAST_HOME, '0);
        send_request(lphm_pkg::OP_LOOKUP, LAST_HOME, '0);
        send_request(lphm_pkg::OP_DELETE, LAST_HOME, '0);
        send_request(lphm_pkg::OP_LOOKUP, LAST_HOME, '0);
        raw = $urandom();
        send_request(lphm_pkg::OP_INSERT, LAST_TWIN, raw);
        send_request(OP_RESERVED, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_RESERVED, '0, '0);
        send_request(lphm_pkg::OP_DELETE, '0, '0);
        send_request(lphm_pkg::OP_INSERT, ZERO_TWIN, 32'h0000_0001);
        send_request(lphm_pkg::OP_LOOKUP, ZERO_TWIN, '0);
        send_request(lphm_pkg::OP_DELETE, LAST_HOME, '0);
        send_request(lphm_pkg::OP_LOOKUP, 31'h5555_5555, '0);
        send_request(lphm_pkg::OP_INSERT, 31'h2AAA_AAAA, 32'h5555_5555);
        send_request(lphm_pkg::OP_LOOKUP, 31'h2AAA_AAAA, '0);
    endtask

    // keys cluster on a few homes around the wrap point so probes collide
    task automatic test_random_traffic();
        int unsigned      roll;
        logic [OP_W-1:0]  op;
        logic [31:0]      raw;
        repeat (RANDOM_REQS) begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
                op = lphm_pkg::OP_INSERT;
            else if (roll < 65)
                op = lphm_pkg::OP_DELETE;
            else if (roll < 95)
                op = lphm_pkg::OP_LOOKUP;
            else
                op = OP_RESERVED;
            if ($urandom_range(0, 15) == 0)
                raw = $urandom();
            else
                raw = (SLOTS - 6 + $urandom_range(0, 15)) % SLOTS
                      + SLOTS * $urandom_range(0, 5);
            send_request(op, raw[KEY_W-1:0], $urandom());
        end
    endtask

    task automatic test_fill_to_capacity();
        logic [31:0] raw;
        int unsigned s;
        // one key homed on each non-occupied slot, so every insert hits at home
        for (int unsigned slot = 0; slot < SLOTS; slot++) begin
            if (tbl_state[slot] != lphm_pkg::SLOT_USED) begin
                raw = ($urandom() % (32'h8000_0000 / SLOTS)) * SLOTS + slot;
                send_request(lphm_pkg::OP_INSERT, raw[KEY_W-1:0], $urandom());
            end
        end
        raw = $urandom();
        // rejected, table full
        send_request(lphm_pkg::OP_INSERT, raw[KEY_W-1:0], $urandom());
        s = $urandom_range(0, SLOTS - 1);
        // overwrite still allowed
        send_request(lphm_pkg::OP_INSERT, tbl_key[s], $urandom());
        send_request(lphm_pkg::OP_LOOKUP, tbl_key[s], '0);
        raw = $urandom();
        send_request(lphm_pkg::OP_LOOKUP, raw[KEY_W-1:0], '0);  // full-length probe miss
        raw = $urandom();
        send_request(lphm_pkg::OP_DELETE, raw[KEY_W-1:0], '0);
    endtask

    task automatic test_reuse_after_delete();
        logic [31:0] raw;
        int unsigned s;
        repeat (30) begin
            s = $urandom_range(0, SLOTS - 1);
            send_request(lphm_pkg::OP_DELETE, tbl_key[s], '0);
        end
        repeat (30) begin
            raw = $urandom();
            send_request(lphm_pkg::OP_INSERT, raw[KEY_W-1:0], $urandom());
        end
        repeat (10) begin
            s = $urandom_range(0, SLOTS - 1);
            if ($urandom_range(0, 1) == 0)
                send_request(lphm_pkg::OP_INSERT, tbl_key[s], $urandom());
            else
                send_request(lphm_pkg::OP_LOOKUP, tbl_key[s], $urandom());
        end
    endtask

    initial begin : reply_checker
        reply_t      want;
        int unsigned stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (pending_replies.size() == 0) begin
                $error("unexpected result beat: status %0d value %h count %0d",
                       m_tuser, m_tdata[31:0], m_tdata[42:32]);
                fail_count++;
            end else begin
                want = pending_replies.pop_front();
                replies_checked++;
                if (want.status == lphm_pkg::RS_NOT_FOUND)
                    misses_seen++;
                if (want.status == lphm_pkg::RS_FULL)
                    full_seen++;
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata[31:0] !== want.value) begin
                    $error("result_value: expected %h, got %h", want.value, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[42:32] !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count, m_tdata[42:32]);
                    fail_count++;
                end
            end
        end
    end

    // covers the clearing sweep after reset and full-length probes
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat accepted for %0d cycles", quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        foreach (tbl_state[i]) begin
            tbl_state[i] = lphm_pkg::SLOT_EMPTY;
            tbl_key[i]   = '0;
            tbl_value[i] = '0;
        end
        tbl_count = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_corners();
        test_random_traffic();
        test_fill_to_capacity();
        test_reuse_after_delete();
        s_tvalid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d requests sent, %0d results checked", reqs_sent, replies_checked);
        $display("covered: %0d misses, %0d full-table rejects, table filled to %0d slots",
                 misses_seen, full_seen, SLOTS);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
